/* hw/rtl/kfpv_pkg.sv */
// Shared types and the micro-program of the two-state Kalman filter sequencer.
// No dependencies; used by kalman_filter_position_velocity_top.
`timescale 1ns / 1ps
`default_nettype none
package kfpv_pkg;

    localparam int SLOT_W    = 5;
    localparam int RAM_DEPTH = 32;
    localparam int PC_W      = 6;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_REGS  = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IPOS = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IVEL = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IPP  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IPV  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IVV  = 4'd7;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [3:0] {
        OP_LDC, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_HALF, OP_OMK, OP_BLE, OP_OUT
    } t_op;

    typedef struct packed {
        t_op   op;
        t_slot dst;
        t_slot a;
        t_slot b;
    } t_uop;

    // scratch RAM slots; the first six hold the filter state
    localparam t_slot SL_POS = 5'd0;
    localparam t_slot SL_VEL = 5'd1;
    localparam t_slot SL_PP  = 5'd2;
    localparam t_slot SL_PV  = 5'd3;
    localparam t_slot SL_VP  = 5'd4;
    localparam t_slot SL_VV  = 5'd5;
    localparam t_slot SL_DT  = 5'd6;
    localparam t_slot SL_Q   = 5'd7;
    localparam t_slot SL_R   = 5'd8;
    localparam t_slot SL_Z   = 5'd9;
    localparam t_slot SL_DT2 = 5'd10;
    localparam t_slot SL_DT3 = 5'd11;
    localparam t_slot SL_DT4 = 5'd12;
    localparam t_slot SL_Q11 = 5'd13;
    localparam t_slot SL_Q12 = 5'd14;
    localparam t_slot SL_Q22 = 5'd15;
    localparam t_slot SL_T1  = 5'd16;
    localparam t_slot SL_T2  = 5'd17;
    localparam t_slot SL_T3  = 5'd18;
    localparam t_slot SL_A11 = 5'd19;
    localparam t_slot SL_A12 = 5'd20;
    localparam t_slot SL_A21 = 5'd21;
    localparam t_slot SL_A22 = 5'd22;
    localparam t_slot SL_S   = 5'd23;
    localparam t_slot SL_XP  = 5'd24;
    localparam t_slot SL_Y   = 5'd25;
    localparam t_slot SL_K1  = 5'd26;
    localparam t_slot SL_K2  = 5'd27;
    localparam t_slot SL_OMK = 5'd28;

    // constant sources for OP_LDC, carried in the a field
    localparam t_slot CS_DT   = 5'd0;
    localparam t_slot CS_Q    = 5'd1;
    localparam t_slot CS_R    = 5'd2;
    localparam t_slot CS_Z    = 5'd3;
    localparam t_slot CS_IPOS = 5'd4;
    localparam t_slot CS_IVEL = 5'd5;
    localparam t_slot CS_IPP  = 5'd6;
    localparam t_slot CS_IPV  = 5'd7;
    localparam t_slot CS_IVV  = 5'd8;

    localparam logic [PC_W-1:0] PC_RUN = 6'd6;
    localparam logic [PC_W-1:0] PC_OUT = 6'd49;

    function automatic t_uop mk(input t_op op, input t_slot d, input t_slot a, input t_slot b);
        t_uop u;
        u.op  = op;
        u.dst = d;
        u.a   = a;
        u.b   = b;
        return u;
    endfunction

    function automatic t_uop prog(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            // reload of the state from the initial-value registers
            6'd0:  u = mk(OP_LDC, SL_POS, CS_IPOS, SL_POS);
            6'd1:  u = mk(OP_LDC, SL_VEL, CS_IVEL, SL_POS);
            6'd2:  u = mk(OP_LDC, SL_PP,  CS_IPP,  SL_POS);
            6'd3:  u = mk(OP_LDC, SL_PV,  CS_IPV,  SL_POS);
            6'd4:  u = mk(OP_LDC, SL_VP,  CS_IPV,  SL_POS);
            6'd5:  u = mk(OP_LDC, SL_VV,  CS_IVV,  SL_POS);
            // per-item operands
            6'd6:  u = mk(OP_LDC, SL_DT,  CS_DT,   SL_POS);
            6'd7:  u = mk(OP_LDC, SL_Q,   CS_Q,    SL_POS);
            6'd8:  u = mk(OP_LDC, SL_R,   CS_R,    SL_POS);
            6'd9:  u = mk(OP_LDC, SL_Z,   CS_Z,    SL_POS);
            // process noise terms
            6'd10: u = mk(OP_MUL, SL_DT2, SL_DT,  SL_DT);
            6'd11: u = mk(OP_MUL, SL_DT3, SL_DT2, SL_DT);
            6'd12: u = mk(OP_MUL, SL_DT4, SL_DT3, SL_DT);
            6'd13: u = mk(OP_MUL, SL_Q11, SL_Q,   SL_DT4);
            6'd14: u = mk(OP_HALF, SL_Q11, SL_Q11, SL_Q11);
            6'd15: u = mk(OP_HALF, SL_Q11, SL_Q11, SL_Q11);
            6'd16: u = mk(OP_MUL, SL_Q12, SL_Q,   SL_DT3);
            6'd17: u = mk(OP_HALF, SL_Q12, SL_Q12, SL_Q12);
            6'd18: u = mk(OP_MUL, SL_Q22, SL_Q,   SL_DT2);
            // predicted covariance
            6'd19: u = mk(OP_MUL, SL_T1,  SL_DT,  SL_VP);
            6'd20: u = mk(OP_ADD, SL_A11, SL_PP,  SL_T1);
            6'd21: u = mk(OP_MUL, SL_T2,  SL_DT,  SL_VV);
            6'd22: u = mk(OP_ADD, SL_T3,  SL_PV,  SL_T2);
            6'd23: u = mk(OP_MUL, SL_T1,  SL_DT,  SL_T3);
            6'd24: u = mk(OP_ADD, SL_A11, SL_A11, SL_T1);
            6'd25: u = mk(OP_ADD, SL_A11, SL_A11, SL_Q11);
            6'd26: u = mk(OP_ADD, SL_A12, SL_T3,  SL_Q12);
            6'd27: u = mk(OP_ADD, SL_T1,  SL_VP,  SL_T2);
            6'd28: u = mk(OP_ADD, SL_A21, SL_T1,  SL_Q12);
            6'd29: u = mk(OP_ADD, SL_A22, SL_VV,  SL_Q22);
            6'd30: u = mk(OP_ADD, SL_S,   SL_A11, SL_R);
            6'd31: u = mk(OP_BLE, SL_S,   SL_S,   SL_S);
            // correction
            6'd32: u = mk(OP_MUL, SL_T1,  SL_DT,  SL_VEL);
            6'd33: u = mk(OP_ADD, SL_XP,  SL_POS, SL_T1);
            6'd34: u = mk(OP_SUB, SL_Y,   SL_Z,   SL_XP);
            6'd35: u = mk(OP_DIV, SL_K1,  SL_A11, SL_S);
            6'd36: u = mk(OP_DIV, SL_K2,  SL_A21, SL_S);
            6'd37: u = mk(OP_OMK, SL_OMK, SL_K1,  SL_K1);
            6'd38: u = mk(OP_MUL, SL_T1,  SL_K1,  SL_Y);
            6'd39: u = mk(OP_ADD, SL_POS, SL_XP,  SL_T1);
            6'd40: u = mk(OP_MUL, SL_T1,  SL_K2,  SL_Y);
            6'd41: u = mk(OP_ADD, SL_VEL, SL_VEL, SL_T1);
            6'd42: u = mk(OP_MUL, SL_PP,  SL_OMK, SL_A11);
            6'd43: u = mk(OP_MUL, SL_PV,  SL_OMK, SL_A12);
            6'd44: u = mk(OP_MUL, SL_T1,  SL_K2,  SL_A11);
            6'd45: u = mk(OP_SUB, SL_VP,  SL_A21, SL_T1);
            6'd46: u = mk(OP_MUL, SL_T1,  SL_K2,  SL_A12);
            6'd47: u = mk(OP_SUB, SL_VV,  SL_A22, SL_T1);
            6'd48: u = mk(OP_OUT, SL_POS, SL_POS, SL_VEL);
            6'd49: u = mk(OP_OUT, SL_POS, SL_POS, SL_VEL);
            default: u = mk(OP_OUT, SL_POS, SL_POS, SL_VEL);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/kfpv_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kfpv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

/* hw/rtl/kalman_filter_position_velocity_top.sv */
// Two-state constant-velocity Kalman filter: sequencer, shared arithmetic unit,
// configuration registers. Depends on kfpv_pkg and kfpv_ram.
//
// Usage:
//   s_axis carries one position measurement per transfer (tdata[31:0], Q16.16).
//   m_axis returns one result per measurement: tdata holds position_est in the
//   low DATA_WIDTH bits and velocity_est above it; tuser[0] is the sat flag.
//   Configuration registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data while the block is idle; every write to a valid index reloads
//   the state from the initial-value registers on the next measurement.
//   The micro-program runs on one arithmetic unit: a plain step passes through
//   fetch, execute and write-back, the branch and output steps through fetch
//   and execute only; each of the 16 multiplies adds four partial products and
//   a rounding state, each of the 2 divides a quotient loop (one quotient bit
//   per cycle) and a final state. A reload adds six load steps. s_axis_tready
//   is high only while the sequencer is idle, so a new measurement is taken
//   only after the run for the last one has ended.
//   A finished result waits in the output register; a stalled receiver holds
//   the next run at its final step until the register is free.
//   Reset restores the register defaults and marks the state for reload.
`timescale 1ns / 1ps
`default_nettype none
module kalman_filter_position_velocity_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [kfpv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [31:0]                     i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [31:0]                     s_axis_tdata,   // measurement
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // position_est, velocity_est
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    output logic [0:0]                           m_axis_tuser    // sat
);
    import kfpv_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int OUT_TW = ((2*W+7)/8)*8;
    localparam int H      = (W+1)/2;
    localparam int ACC_W  = 2*W;
    localparam int QW     = W+F;
    localparam int DCW    = $clog2(QW);
    localparam int MW     = (ACC_W > QW) ? ACC_W : QW;
    localparam int OW     = ((F+2 > W) ? F+2 : W) + 1;
    localparam int CLW    = (OW > 34) ? OW : 34;

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_EXEC, S_MUL, S_MRND, S_DIV, S_DFIN, S_WB
    } t_state;

    // configuration registers
    logic [16:0] r_dt;
    logic [30:0] r_q, r_r, r_ipp, r_ivv;
    logic [31:0] r_ipos, r_ivel, r_ipv;
    logic        r_dirty;

    // sequencer and unit
    t_state               r_state;
    logic [PC_W-1:0]      r_pc;
    logic [31:0]          r_z;
    logic                 r_sat;
    logic [W-1:0]         r_res;
    logic                 r_neg;
    logic [W-1:0]         r_mx, r_my;
    logic [1:0]           r_mcnt;
    logic [ACC_W-1:0]     r_acc;
    logic [QW-1:0]        r_quo;
    logic [W-1:0]         r_rem;
    logic [W-1:0]         r_dvs;
    logic [DCW-1:0]       r_dcnt;
    logic                 r_mv;
    logic [OUT_TW-1:0]    r_od;
    logic                 r_ou;

    t_uop                 uop;
    logic [W-1:0]         ram_a, ram_b;
    logic signed [W-1:0]  opa, opb;
    logic                 in_xfer;
    logic                 out_load;

    function automatic logic [W:0] clamp_s(input logic signed [CLW-1:0] v);
        logic signed [CLW-1:0] vmax, vmin;
        vmax = $signed((CLW'(1) << (W-1)) - CLW'(1));
        vmin = ~vmax;
        if (v > vmax) return {1'b1, vmax[W-1:0]};
        if (v < vmin) return {1'b1, vmin[W-1:0]};
        return {1'b0, v[W-1:0]};
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic [W:0] sat_mag(input logic [MW-1:0] m, input logic neg);
        logic [MW-1:0] lim, mm;
        lim = neg ? (MW'(1) << (W-1)) : ((MW'(1) << (W-1)) - MW'(1));
        mm  = (m > lim) ? lim : m;
        return {m > lim, W'(MW'(0) - mm) & {W{neg}} | W'(mm) & {W{~neg}}};
    endfunction

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt    <= 17'd655;
            r_q     <= 31'd65536;
            r_r     <= 31'd65536;
            r_ipos  <= '0;
            r_ivel  <= '0;
            r_ipp   <= 31'd65536;
            r_ipv   <= '0;
            r_ivv   <= 31'd65536;
            r_dirty <= 1'b1;
        end else begin
            if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_REGS))) begin
                r_dirty <= 1'b1;
            end else if (in_xfer) begin
                r_dirty <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_DT:   r_dt   <= i_cfg_data[16:0];
                    REG_Q:    r_q    <= i_cfg_data[30:0];
                    REG_R:    r_r    <= i_cfg_data[30:0];
                    REG_IPOS: r_ipos <= i_cfg_data;
                    REG_IVEL: r_ivel <= i_cfg_data;
                    REG_IPP:  r_ipp  <= i_cfg_data[30:0];
                    REG_IPV:  r_ipv  <= i_cfg_data;
                    REG_IVV:  r_ivv  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------- datapath
    assign uop      = prog(r_pc);
    assign opa      = $signed(ram_a);
    assign opb      = $signed(ram_b);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == S_EXEC) && (uop.op == OP_OUT) && (!r_mv || m_axis_tready);

    kfpv_ram #(
        .WIDTH (W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (r_state == S_WB),
        .i_waddr   (uop.dst),
        .i_wdata   (r_res),
        .i_raddr_a (uop.a),
        .i_raddr_b (uop.b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    logic [W:0]        n_ldc, n_add, n_sub, n_omk, n_mrnd, n_dfin;
    logic [W-1:0]      n_half;
    logic signed [W:0] half_t;
    logic [H-1:0]      pa, pb;
    logic [2*H-1:0]    pprod;
    logic [ACC_W-1:0]  pshift;
    logic [W-1:0]      rem2;
    logic              rem_ge;

    always_comb begin
        unique case (uop.a)
            CS_DT:   n_ldc = clamp_s(CLW'($signed({16'b0, r_dt})));
            CS_Q:    n_ldc = clamp_s(CLW'($signed({2'b0, r_q})));
            CS_R:    n_ldc = clamp_s(CLW'($signed({2'b0, r_r})));
            CS_Z:    n_ldc = clamp_s(CLW'($signed({r_z[31], r_z})));
            CS_IPOS: n_ldc = clamp_s(CLW'($signed({r_ipos[31], r_ipos})));
            CS_IVEL: n_ldc = clamp_s(CLW'($signed({r_ivel[31], r_ivel})));
            CS_IPP:  n_ldc = clamp_s(CLW'($signed({2'b0, r_ipp})));
            CS_IPV:  n_ldc = clamp_s(CLW'($signed({r_ipv[31], r_ipv})));
            CS_IVV:  n_ldc = clamp_s(CLW'($signed({2'b0, r_ivv})));
            default: n_ldc = '0;
        endcase
    end

    assign n_add  = clamp_s(CLW'(opa) + CLW'(opb));
    assign n_sub  = clamp_s(CLW'(opa) - CLW'(opb));
    assign n_omk  = clamp_s($signed(CLW'(1) << F) - CLW'(opa));
    // truncate toward zero: bias negative values by one before the shift
    assign half_t = $signed({opa[W-1], opa}) + $signed({{W{1'b0}}, opa[W-1]});
    assign n_half = W'(half_t >>> 1);

    // partial products: low*low, low*high, high*low, high*high
    assign pa    = r_mcnt[1] ? H'(r_mx >> H) : H'(r_mx);
    assign pb    = r_mcnt[0] ? H'(r_my >> H) : H'(r_my);
    assign pprod = pa * pb;
    always_comb begin
        case (r_mcnt)
            2'd0:    pshift = ACC_W'(pprod);
            2'd3:    pshift = ACC_W'(pprod) << (2*H);
            default: pshift = ACC_W'(pprod) << H;
        endcase
    end
    assign n_mrnd = sat_mag(MW'((r_acc + (ACC_W'(1) << (F-1))) >> F), r_neg);

    assign rem2   = {r_rem[W-2:0], r_quo[QW-1]};
    assign rem_ge = rem2 >= r_dvs;
    assign n_dfin = sat_mag(MW'(r_quo), r_neg);

    // ------------------------------------------------------------ sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_sat   <= 1'b0;
            r_mv    <= 1'b0;
        end else begin
            if (out_load) begin
                r_mv <= 1'b1;
            end else if (m_axis_tready) begin
                r_mv <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_z     <= s_axis_tdata;
                        r_pc    <= r_dirty ? '0 : PC_RUN;
                        r_sat   <= 1'b0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_EXEC;
                S_EXEC: begin
                    case (uop.op)
                        OP_LDC: begin
                            r_res   <= n_ldc[W-1:0];
                            r_state <= S_WB;
                        end
                        OP_ADD: begin
                            r_res   <= n_add[W-1:0];
                            r_sat   <= r_sat | n_add[W];
                            r_state <= S_WB;
                        end
                        OP_SUB: begin
                            r_res   <= n_sub[W-1:0];
                            r_sat   <= r_sat | n_sub[W];
                            r_state <= S_WB;
                        end
                        OP_OMK: begin
                            r_res   <= n_omk[W-1:0];
                            r_sat   <= r_sat | n_omk[W];
                            r_state <= S_WB;
                        end
                        OP_HALF: begin
                            r_res   <= n_half;
                            r_state <= S_WB;
                        end
                        OP_MUL: begin
                            r_neg   <= opa[W-1] ^ opb[W-1];
                            r_mx    <= mag(opa);
                            r_my    <= mag(opb);
                            r_acc   <= '0;
                            r_mcnt  <= '0;
                            r_state <= S_MUL;
                        end
                        OP_DIV: begin
                            r_neg   <= opa[W-1];
                            r_quo   <= QW'(mag(opa)) << F;
                            r_rem   <= '0;
                            r_dvs   <= ram_b;
                            r_dcnt  <= '0;
                            r_state <= S_DIV;
                        end
                        OP_BLE: begin
                            // innovation variance not positive: keep state, flag it
                            if (opa <= 0) begin
                                r_sat <= 1'b1;
                                r_pc  <= PC_OUT;
                            end else begin
                                r_pc  <= r_pc + 1'b1;
                            end
                            r_state <= S_FETCH;
                        end
                        default: begin
                            // hold the run here until the output register is free
                            if (out_load) begin
                                r_od    <= OUT_TW'({ram_b, ram_a});
                                r_ou    <= r_sat;
                                r_state <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_MUL: begin
                    r_acc  <= r_acc + pshift;
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == 2'd3) begin
                        r_state <= S_MRND;
                    end
                end
                S_MRND: begin
                    r_res   <= n_mrnd[W-1:0];
                    r_sat   <= r_sat | n_mrnd[W];
                    r_state <= S_WB;
                end
                S_DIV: begin
                    r_rem  <= rem_ge ? rem2 - r_dvs : rem2;
                    r_quo  <= {r_quo[QW-2:0], rem_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCW'(QW-1)) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    r_res   <= n_dfin[W-1:0];
                    r_sat   <= r_sat | n_dfin[W];
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_pc    <= r_pc + 1'b1;
                    r_state <= S_FETCH;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ou;

endmodule
`default_nettype wire

/* tb/kalman_filter_position_velocity_top_tb.sv */
// Testbench of the two-state constant-velocity Kalman filter: drives measurements
// and register writes, predicts every result with its own fixed-point filter.
// Depends on kfpv_pkg and kalman_filter_position_velocity_top.
`timescale 1ns / 1ps
module kalman_filter_position_velocity_top_tb;
    import kfpv_pkg::*;

    localparam int FB = 16;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint ONE_Q = 64'sd65536;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic        sat;
    } t_estimate;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // measurement
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // position_est, velocity_est
    logic [0:0]  m_axis_tuser;        // sat

    kalman_filter_position_velocity_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // filter model state
    logic [31:0] cfg_regs [0:NUM_REGS-1];
    longint est_pos, est_vel, p_pp, p_pv, p_vp, p_vv;
    t_estimate expected_estimates[$];
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  idle_enable = 1'b1;
    int  hold_off_cycles = 0;

    function automatic longint clamp_q(longint v, ref bit f);
        if (v > VMAX) begin f = 1'b1; return VMAX; end
        if (v < VMIN) begin f = 1'b1; return VMIN; end
        return v;
    endfunction

    function automatic longint from_mag(logic [127:0] m, bit neg, ref bit f);
        logic [127:0] lim;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (m > lim) begin f = 1'b1; m = lim; end
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    // exact product, round half away from zero, saturate
    function automatic longint qmul(longint a, longint b, ref bit f);
        logic [127:0] p;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        p = (p + (128'd1 << (FB - 1))) >> FB;
        return from_mag(p, neg, f);
    endfunction

    function automatic longint qdiv(longint num, longint den, ref bit f);
        logic [127:0] n;
        bit neg;
        neg = num < 0;
        n = 128'(num < 0 ? -num : num);
        return from_mag((n << FB) / 128'(den), neg, f);
    endfunction

    function automatic longint reg_signed(int idx);
        return longint'(signed'(cfg_regs[idx]));
    endfunction

    function automatic longint reg_unsigned(int idx);
        return longint'({32'd0, cfg_regs[idx]});
    endfunction

    function automatic void reload_filter();
        est_pos = reg_signed(REG_IPOS);
        est_vel = reg_signed(REG_IVEL);
        p_pp    = reg_unsigned(REG_IPP);
        p_pv    = reg_signed(REG_IPV);
        p_vp    = p_pv;
        p_vv    = reg_unsigned(REG_IVV);
    endfunction

    function automatic void reset_filter();
        cfg_regs[REG_DT] = 32'd655;
        cfg_regs[REG_Q]  = 32'd65536;
        cfg_regs[REG_R]  = 32'd65536;
        cfg_regs[REG_IPOS] = 32'd0;
        cfg_regs[REG_IVEL] = 32'd0;
        cfg_regs[REG_IPP]  = 32'd65536;
        cfg_regs[REG_IPV]  = 32'd0;
        cfg_regs[REG_IVV]  = 32'd65536;
        reload_filter();
    endfunction

    function automatic t_estimate filter_update(logic [31:0] meas);
        t_estimate e;
        bit f;
        longint z, dt, q, r, dt2, dt3, dt4, q11, q12, q22;
        longint a11, a12, a21, a22, s, xp, y, k1, k2, omk, t;
        f = 1'b0;
        z  = longint'(signed'(meas));
        dt = reg_unsigned(REG_DT);
        q  = reg_unsigned(REG_Q);
        r  = reg_unsigned(REG_R);
        dt2 = qmul(dt, dt, f);
        dt3 = qmul(dt2, dt, f);
        dt4 = qmul(dt3, dt, f);
        q11 = qmul(q, dt4, f) / 4;
        q12 = qmul(q, dt3, f) / 2;
        q22 = qmul(q, dt2, f);
        a11 = clamp_q(p_pp + qmul(dt, p_vp, f), f);
        t   = clamp_q(p_pv + qmul(dt, p_vv, f), f);
        a11 = clamp_q(a11 + qmul(dt, t, f), f);
        a11 = clamp_q(a11 + q11, f);
        a12 = clamp_q(t + q12, f);
        a21 = clamp_q(clamp_q(p_vp + qmul(dt, p_vv, f), f) + q12, f);
        a22 = clamp_q(p_vv + q22, f);
        s   = clamp_q(a11 + r, f);
        if (s <= 0) begin
            // hold the state, flag it
            e.pos = est_pos[31:0];
            e.vel = est_vel[31:0];
            e.sat = 1'b1;
            return e;
        end
        xp  = clamp_q(est_pos + qmul(dt, est_vel, f), f);
        y   = clamp_q(z - xp, f);
        k1  = qdiv(a11, s, f);
        k2  = qdiv(a21, s, f);
        omk = clamp_q(ONE_Q - k1, f);
        est_pos = clamp_q(xp + qmul(k1, y, f), f);
        est_vel = clamp_q(est_vel + qmul(k2, y, f), f);
        p_pp = qmul(omk, a11, f);
        p_pv = qmul(omk, a12, f);
        p_vp = clamp_q(a21 - qmul(k2, a11, f), f);
        p_vv = clamp_q(a22 - qmul(k2, a12, f), f);
        e.pos = est_pos[31:0];
        e.vel = est_vel[31:0];
        e.sat = f;
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, want %h at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !i_rst_n ? 1'b0 : (!idle_enable || $urandom_range(99) >= 28);
        end
    end

    // check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_estimate e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_estimates.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
            end else begin
                e = expected_estimates.pop_front();
                if (m_axis_tdata[31:0] !== e.pos)
                    report_mismatch("position_est", m_axis_tdata[31:0], e.pos);
                if (m_axis_tdata[63:32] !== e.vel)
                    report_mismatch("velocity_est", m_axis_tdata[63:32], e.vel);
                if (m_axis_tuser[0] !== e.sat)
                    report_mismatch("sat", {31'd0, m_axis_tuser[0]}, {31'd0, e.sat});
            end
        end
    end

    // always advance at least one edge, so valid is never dropped and raised in one step
    task automatic send_measurement(logic [31:0] meas);
        do @(posedge i_clk); while (idle_enable && $urandom_range(99) < 28);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= meas;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_estimates.push_back(filter_update(meas));
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (expected_estimates.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // only while idle; a valid index reloads the state
    task automatic write_register(int idx, logic [31:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[CFG_IDX_W-1:0];
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < NUM_REGS) begin
            case (idx)
                REG_DT: cfg_regs[idx] = {15'd0, value[16:0]};
                REG_Q, REG_R, REG_IPP, REG_IVV: cfg_regs[idx] = {1'b0, value[30:0]};
                default: cfg_regs[idx] = value;
            endcase
            reload_filter();
        end
    endtask

    function automatic logic [31:0] rand_meas();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    task automatic test_defaults();
        send_measurement(32'h0000_0000);
        send_measurement(32'h7fff_ffff);
        send_measurement(32'h8000_0000);
        send_measurement(32'hffff_ffff);
        send_measurement(32'h0001_0000);
        send_measurement(32'h5555_5555);
        send_measurement(32'haaaa_aaaa);
    endtask

    task automatic test_register_extremes();
        write_register(REG_DT, 32'd65536);
        write_register(REG_Q, 32'h7fff_ffff);
        write_register(REG_IPOS, 32'h7fff_ffff);
        write_register(REG_IVEL, 32'h8000_0000);
        write_register(REG_IPP, 32'h7fff_ffff);
        write_register(REG_IPV, 32'h8000_0000);
        write_register(REG_IVV, 32'h7fff_ffff);
        write_register(REG_R, 32'h7fff_ffff);
        send_measurement(32'h0000_0000);
        send_measurement(32'h8000_0000);
        // sample period beyond its range, used as written
        write_register(REG_DT, 32'h0001_ffff);
        send_measurement(32'h1234_5678);
        write_register(REG_DT, 32'd1);
        write_register(REG_Q, 32'd0);
        write_register(REG_R, 32'd0);
        write_register(REG_IPP, 32'd0);
        write_register(REG_IVV, 32'd0);
        write_register(REG_IPV, 32'h8000_0000);
        // innovation variance not positive: state held, flag set
        send_measurement(32'h0100_0000);
        send_measurement(32'hff00_0000);
        // out-of-range index: ignored, no reload
        write_register(9, 32'hffff_ffff);
        write_register(15, 32'h0);
        send_measurement(32'h0000_1000);
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            write_register(REG_DT, $urandom_range(65536, 1));
            write_register(REG_Q, $urandom_range(3) == 0 ? $urandom() : $urandom_range(200000));
            write_register(REG_R, $urandom_range(3) == 0 ? $urandom() : $urandom_range(200000));
            write_register(REG_IPOS, $urandom());
            write_register(REG_IVEL, $urandom_range(1) ? $urandom() : $urandom_range(70000));
            write_register(REG_IPP, $urandom_range(300000));
            write_register(REG_IPV, 32'($signed($urandom_range(200000)) - 100000));
            write_register(REG_IVV, $urandom_range(1) ? $urandom() : $urandom_range(300000));
            idle_enable = (phase != 3);
            for (int n = 0; n < 50; n++) send_measurement(rand_meas());
            idle_enable = 1'b1;
        end
    endtask

    task automatic test_back_pressure();
        write_register(REG_DT, 32'd655);
        hold_off_cycles = 3000;
        for (int n = 0; n < 20; n++) send_measurement(rand_meas());
        // pause until every result is back
        while (expected_estimates.size() != 0) @(posedge i_clk);
        for (int n = 0; n < 20; n++) send_measurement(rand_meas());
    endtask

    initial begin
        reset_filter();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_register_extremes();
        test_random_settings();
        test_back_pressure();
        drain_results();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
